// ===== design/ihl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihl_pkg
// Shared types, codes and the log-bin threshold table of the histogram.
// ----------------------------------------------------------------------------
package ihl_pkg;

  localparam int IDX_W      = 16;
  localparam int CNT_W      = 32;
  localparam int PIX_W      = 32;
  localparam int BIN_DEPTH  = 1 << IDX_W;

  localparam int LOG_STEPS       = 255;
  localparam int SEARCH_BITS     = 8;
  localparam int STEPS_PER_STAGE = 2;
  localparam int SEARCH_STAGES   = SEARCH_BITS / STEPS_PER_STAGE;

  localparam int WIDE_W = 8192;
  localparam logic [PIX_W-1:0] FULL_SCALE = '1;
  localparam real LN_STEP = $ln(4294967295.0) / real'(LOG_STEPS);

  typedef enum logic [1:0] {
    OP_ACCUM    = 2'd0,
    OP_READ     = 2'd1,
    OP_READ_CLR = 2'd2,
    OP_NONE     = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    MODE_BYTE = 2'd0,
    MODE_WORD = 2'd1,
    MODE_LOG  = 2'd2,
    MODE_OFF  = 2'd3
  } mode_e;

  typedef logic [PIX_W-1:0] thresh_tab_t [LOG_STEPS];

  // one item on its way through the log search
  typedef struct packed {
    logic             valid;
    logic             rd;
    logic             clr;
    logic             is_log;
    logic [PIX_W-1:0] pix;
    logic [IDX_W-1:0] idx;
  } loc_t;

  // item handed to the counter bank
  typedef struct packed {
    logic             valid;
    logic             rd;
    logic             clr;
    logic [IDX_W-1:0] idx;
  } ihl_item_t;

  // c^255 in exact wide arithmetic
  function automatic logic [WIDE_W-1:0] pow_steps(logic [PIX_W-1:0] c);
    logic [WIDE_W-1:0] p;
    logic [WIDE_W-1:0] b;
    p = WIDE_W'(1);
    b = WIDE_W'(c);
    for (int i = 0; i < SEARCH_BITS; i++) begin
      p = p * b;
      if (i < SEARCH_BITS - 1) b = b * b;
    end
    return p;
  endfunction

  // tab[k-1] = least t with t^255 >= (2^32-1)^k; real estimate, exact check near integers
  function automatic thresh_tab_t build_log_thresh();
    thresh_tab_t       tab;
    logic [WIDE_W-1:0] mk;
    real               r;
    real               fr;
    longint            t;
    mk = WIDE_W'(1);
    for (int k = 1; k <= LOG_STEPS; k++) begin
      mk = mk * WIDE_W'(FULL_SCALE);
      r  = $exp(LN_STEP * real'(k));
      t  = longint'($ceil(r));
      if (t > longint'(FULL_SCALE)) t = longint'(FULL_SCALE);
      if (t < 1) t = 1;
      fr = r - $floor(r);
      if (fr < 0.01 || fr > 0.99) begin
        for (int i = 0; i < 4; i++) begin
          if (pow_steps(PIX_W'(t)) < mk) t = t + 1;
        end
        for (int i = 0; i < 4; i++) begin
          if (t > 1 && pow_steps(PIX_W'(t - 1)) >= mk) t = t - 1;
        end
      end
      tab[k-1] = PIX_W'(t);
    end
    return tab;
  endfunction

  localparam thresh_tab_t LOG_THRESH = build_log_thresh();

  // one step of the binary search over the monotone threshold table
  function automatic logic [SEARCH_BITS-1:0] log_step(logic [PIX_W-1:0] v,
                                                      logic [SEARCH_BITS-1:0] bin,
                                                      int bit_pos);
    logic [SEARCH_BITS-1:0] cand;
    cand = bin | (SEARCH_BITS'(1) << bit_pos);
    if (v >= LOG_THRESH[cand - SEARCH_BITS'(1)]) return cand;
    return bin;
  endfunction

endpackage

// ===== design/ihl_bin_locate.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihl_bin_locate
// Decodes items into a bin index; log-mode pixels run a pipelined search.
// ----------------------------------------------------------------------------
module ihl_bin_locate (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       advance_i,
  input  logic                       take_i,
  input  logic [1:0]                 op_i,
  input  logic [ihl_pkg::PIX_W-1:0]  pixel_value_i,
  input  logic [ihl_pkg::IDX_W-1:0]  bin_select_i,
  input  logic [1:0]                 pixel_mode_i,
  output ihl_pkg::ihl_item_t         item_o
);

  ihl_pkg::loc_t st_q [ihl_pkg::SEARCH_STAGES+1];
  ihl_pkg::loc_t st_d [ihl_pkg::SEARCH_STAGES+1];

  logic is_rd;
  logic is_acc;

  always_comb begin
    is_rd  = (op_i == ihl_pkg::OP_READ) || (op_i == ihl_pkg::OP_READ_CLR);
    is_acc = (op_i == ihl_pkg::OP_ACCUM);

    st_d[0].rd     = is_rd;
    st_d[0].clr    = (op_i == ihl_pkg::OP_READ_CLR);
    st_d[0].pix    = pixel_value_i;
    st_d[0].is_log = is_acc && (pixel_mode_i == ihl_pkg::MODE_LOG);
    st_d[0].valid  = take_i && (is_rd ||
                     (is_acc && ((pixel_mode_i == ihl_pkg::MODE_BYTE) ||
                                 (pixel_mode_i == ihl_pkg::MODE_WORD) ||
                                 ((pixel_mode_i == ihl_pkg::MODE_LOG) &&
                                  (pixel_value_i != '0)))));
    if (is_rd) begin
      st_d[0].idx = bin_select_i;
    end else if (pixel_mode_i == ihl_pkg::MODE_BYTE) begin
      st_d[0].idx = ihl_pkg::IDX_W'(pixel_value_i[7:0]);
    end else if (pixel_mode_i == ihl_pkg::MODE_WORD) begin
      st_d[0].idx = pixel_value_i[ihl_pkg::IDX_W-1:0];
    end else begin
      st_d[0].idx = '0;
    end

    for (int s = 1; s <= ihl_pkg::SEARCH_STAGES; s++) begin
      st_d[s] = st_q[s-1];
      if (st_q[s-1].is_log) begin
        for (int j = 0; j < ihl_pkg::STEPS_PER_STAGE; j++) begin
          st_d[s].idx[ihl_pkg::SEARCH_BITS-1:0] = ihl_pkg::log_step(
            st_d[s].pix, st_d[s].idx[ihl_pkg::SEARCH_BITS-1:0],
            ihl_pkg::SEARCH_BITS - 1 - ihl_pkg::STEPS_PER_STAGE * (s - 1) - j);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s <= ihl_pkg::SEARCH_STAGES; s++) begin
        st_q[s] <= '0;
      end
    end else if (advance_i) begin
      for (int s = 0; s <= ihl_pkg::SEARCH_STAGES; s++) begin
        st_q[s] <= st_d[s];
      end
    end
  end

  assign item_o.valid = st_q[ihl_pkg::SEARCH_STAGES].valid;
  assign item_o.rd    = st_q[ihl_pkg::SEARCH_STAGES].rd;
  assign item_o.clr   = st_q[ihl_pkg::SEARCH_STAGES].clr;
  assign item_o.idx   = st_q[ihl_pkg::SEARCH_STAGES].idx;

endmodule

// ===== design/ihl_count_bank.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihl_count_bank
// Bin counter memory with read-modify-write, forwarding, clear sweep and
// result register.
// ----------------------------------------------------------------------------
module ihl_count_bank (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ihl_pkg::ihl_item_t         item_i,
  output logic                       advance_o,
  output logic                       clearing_o,
  input  logic                       out_stall_i,
  output logic                       out_valid_o,
  output logic [ihl_pkg::CNT_W-1:0]  bin_count_o,
  output logic [ihl_pkg::IDX_W-1:0]  bin_echo_o
);

  logic [ihl_pkg::CNT_W-1:0] mem [ihl_pkg::BIN_DEPTH];

  logic [ihl_pkg::IDX_W:0]   clr_cnt_q;
  ihl_pkg::ihl_item_t        b_q;
  logic [ihl_pkg::CNT_W-1:0] rdata_q;
  logic                      fwd_hit_q;
  logic [ihl_pkg::CNT_W-1:0] fwd_data_q;
  logic                      out_valid_q;
  logic [ihl_pkg::CNT_W-1:0] count_q;
  logic [ihl_pkg::IDX_W-1:0] echo_q;

  logic                      clearing;
  logic                      advance;
  logic                      b_we;
  logic [ihl_pkg::CNT_W-1:0] cur;
  logic [ihl_pkg::CNT_W-1:0] b_wdata;
  logic                      mem_we;
  logic [ihl_pkg::IDX_W-1:0] mem_waddr;
  logic [ihl_pkg::CNT_W-1:0] mem_wdata;

  always_comb begin
    clearing = !clr_cnt_q[ihl_pkg::IDX_W];
    advance  = !(b_q.valid && b_q.rd && out_valid_q && out_stall_i);
    cur      = fwd_hit_q ? fwd_data_q : rdata_q;
    if (b_q.rd) begin
      b_wdata = '0;
    end else if (cur == '1) begin
      b_wdata = cur;
    end else begin
      b_wdata = cur + ihl_pkg::CNT_W'(1);
    end
    b_we      = b_q.valid && advance && (!b_q.rd || b_q.clr);
    mem_we    = clearing || b_we;
    mem_waddr = clearing ? clr_cnt_q[ihl_pkg::IDX_W-1:0] : b_q.idx;
    mem_wdata = clearing ? '0 : b_wdata;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (advance) rdata_q <= mem[item_i.idx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q   <= '0;
      b_q         <= '0;
      fwd_hit_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (clearing) clr_cnt_q <= clr_cnt_q + (ihl_pkg::IDX_W+1)'(1);
      if (advance) begin
        b_q       <= item_i;
        fwd_hit_q <= b_we && (b_q.idx == item_i.idx);
      end
      if (b_q.valid && b_q.rd && advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      fwd_data_q <= b_wdata;
    end
    if (b_q.valid && b_q.rd && advance) begin
      count_q <= cur;
      echo_q  <= b_q.idx;
    end
  end

  assign advance_o   = advance;
  assign clearing_o  = clearing;
  assign out_valid_o = out_valid_q;
  assign bin_count_o = count_q;
  assign bin_echo_o  = echo_q;

endmodule

// ===== design/intensity_histogram_log_bins.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// intensity_histogram_log_bins
// Pixel intensity histogram: byte, 16-bit or log-binned 32-bit pixels,
// saturating counters, read and read-and-clear of single bins.
// Reads pass the locate stages, bank stage and result register. Throughput:
// one item per cycle while in_stall_o is low; the memory read-modify-write
// forwards back-to-back hits on the same bin; the log search is a 4-stage
// pipeline. Reset: after rst_ni releases, a clear sweep zeroes the 65536
// bins, one per cycle, with in_stall_o high; pixel_mode resets to 0.
// ----------------------------------------------------------------------------
module intensity_histogram_log_bins (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 op_i,
  input  logic [ihl_pkg::PIX_W-1:0]  pixel_value_i,
  input  logic [ihl_pkg::IDX_W-1:0]  bin_select_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [ihl_pkg::CNT_W-1:0]  bin_count_o,
  output logic [ihl_pkg::IDX_W-1:0]  bin_echo_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  logic [1:0]         pixel_mode_q;
  logic               advance;
  logic               clearing;
  logic               take;
  ihl_pkg::ihl_item_t item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_mode_q <= ihl_pkg::MODE_BYTE;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      pixel_mode_q <= pwdata[1:0];
    end
  end

  assign pready     = 1'b1;
  assign prdata     = paddr[2] ? '0 : {30'b0, pixel_mode_q};
  assign in_stall_o = clearing || !advance;
  assign take       = in_valid_i && !in_stall_o;

  ihl_bin_locate u_locate (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .advance_i     (advance),
    .take_i        (take),
    .op_i          (op_i),
    .pixel_value_i (pixel_value_i),
    .bin_select_i  (bin_select_i),
    .pixel_mode_i  (pixel_mode_q),
    .item_o        (item)
  );

  ihl_count_bank u_bank (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item),
    .advance_o   (advance),
    .clearing_o  (clearing),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .bin_count_o (bin_count_o),
    .bin_echo_o  (bin_echo_o)
  );

endmodule

// ===== tb/sv/ihl_hist_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihl_hist_checker
// Watches the item channels and the register port of the histogram, keeps its
// own bin counters and log-bin edges, predicts every bin read and compares
// each returned read field by field, in order.
// ----------------------------------------------------------------------------
module ihl_hist_checker
  import ihl_pkg::*;
#(
  parameter logic [2:0] MODE_ADDR = 3'd0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  logic [1:0]       op_i,
  input  logic [PIX_W-1:0] pixel_value_i,
  input  logic [IDX_W-1:0] bin_select_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  logic [CNT_W-1:0] bin_count_i,
  input  logic [IDX_W-1:0] bin_echo_i,
  input  logic             psel_i,
  input  logic             penable_i,
  input  logic             pwrite_i,
  input  logic [2:0]       paddr_i,
  input  logic [31:0]      pwdata_i,
  input  logic [31:0]      prdata_i,
  input  logic             pready_i,
  output int               errors_o,
  output int               pending_o
);

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [IDX_W-1:0] echo;
  } bin_read_t;

  bit   [CNT_W-1:0] tally [BIN_DEPTH];
  logic [PIX_W-1:0] log_edge [1:LOG_STEPS];
  mode_e            mode_q = MODE_BYTE;
  bin_read_t        reads_due [$];
  int               fail_seen = 0;
  int               due_len = 0;

  assign errors_o  = fail_seen;
  assign pending_o = due_len;

  // t^255 as x^(2^(n+1)-1) = (x^(2^n-1))^2 * x
  function automatic logic [8191:0] pow_255(longint t);
    logic [8191:0] acc;
    logic [8191:0] b;
    b   = 8192'(t);
    acc = b;
    repeat (7) acc = acc * acc * b;
    return acc;
  endfunction

  function automatic logic [8191:0] full_scale_pow(int k);
    logic [8191:0] acc;
    logic [7:0]    e;
    e   = 8'(k);
    acc = 8192'(1);
    for (int i = 7; i >= 0; i--) begin
      acc = acc * acc;
      if (e[i]) acc = acc * 8192'(FULL_SCALE);
    end
    return acc;
  endfunction

  // least t with t^255 >= (2^32-1)^k; exact fixup only when the estimate is near an integer
  function automatic logic [PIX_W-1:0] edge_at(int k);
    real           r;
    real           fr;
    real           w;
    longint        t;
    logic [8191:0] target;
    if (k == LOG_STEPS) return FULL_SCALE;
    r  = $exp($ln(4294967295.0) * real'(k) / real'(LOG_STEPS));
    t  = longint'($ceil(r));
    fr = r - $floor(r);
    w  = 1.0e-6 + r * 1.0e-13;
    if (fr < w || fr > 1.0 - w) begin
      target = full_scale_pow(k);
      while (t > 1 && pow_255(t - 1) >= target) t = t - 1;
      while (pow_255(t) < target) t = t + 1;
    end
    return t[PIX_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] log_bin(logic [PIX_W-1:0] v);
    logic [IDX_W-1:0] n;
    n = '0;
    for (int k = 1; k <= LOG_STEPS; k++) begin
      if (v >= log_edge[k]) n = n + 1'b1;
    end
    return n;
  endfunction

  function automatic void bump(logic [IDX_W-1:0] idx);
    if (tally[idx] != '1) tally[idx] = tally[idx] + 1'b1;
  endfunction

  function automatic void tally_item(op_e o, logic [PIX_W-1:0] p, logic [IDX_W-1:0] s);
    bin_read_t r;
    case (o)
      OP_ACCUM: begin
        case (mode_q)
          MODE_BYTE: bump(IDX_W'(p[7:0]));
          MODE_WORD: bump(p[15:0]);
          MODE_LOG:  if (p != '0) bump(log_bin(p));
          default: ;
        endcase
      end
      OP_READ, OP_READ_CLR: begin
        r.count = tally[s];
        r.echo  = s;
        reads_due.push_back(r);
        if (o == OP_READ_CLR) tally[s] = '0;
      end
      default: ;
    endcase
  endfunction

  initial begin
    for (int k = 1; k <= LOG_STEPS; k++) log_edge[k] = edge_at(k);
  end

  always @(posedge clk_i) begin
    bin_read_t want;
    if (rst_ni) begin
      if (psel_i && penable_i && pready_i && paddr_i == MODE_ADDR) begin
        if (pwrite_i) begin
          mode_q = mode_e'(pwdata_i[1:0]);
        end else if (prdata_i !== 32'(mode_q)) begin
          $error("pixel_mode readback: expected %0d, got %0d", mode_q, prdata_i);
          fail_seen++;
        end
      end
      if (in_valid_i && !in_stall_i) tally_item(op_e'(op_i), pixel_value_i, bin_select_i);
      if (out_valid_i && !out_stall_i) begin
        if (reads_due.size() == 0) begin
          $error("unexpected bin read: bin_count %0d, bin_echo %0d", bin_count_i, bin_echo_i);
          fail_seen++;
        end else begin
          want = reads_due.pop_front();
          if (bin_count_i !== want.count) begin
            $error("bin_count: expected %0d, got %0d", want.count, bin_count_i);
            fail_seen++;
          end
          if (bin_echo_i !== want.echo) begin
            $error("bin_echo: expected %0d, got %0d", want.echo, bin_echo_i);
            fail_seen++;
          end
        end
      end
      due_len <= reads_due.size();
    end
  end

endmodule

// ===== tb/sv/intensity_histogram_log_bins_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// intensity_histogram_log_bins_tb
// Drives pixel and bin-read items into the histogram in every pixel mode,
// directed corner items first, then random traffic around a few busy bins
// and the log-bin edges, with random gaps and stalls on both channels and
// one long output stall. A separate checker predicts and compares.
// ----------------------------------------------------------------------------
module intensity_histogram_log_bins_tb;
  import ihl_pkg::*;

  localparam logic [2:0] MODE_ADDR     = 3'd0;
  localparam int         IDLE_LIMIT    = 250_000;
  localparam int         SETTLE_CYCLES = 12;
  localparam int         HOLD_CYCLES   = 300;
  localparam int         PHASE_ITEMS   = 70;
  localparam mode_e      PLAN [7] = '{MODE_WORD, MODE_LOG, MODE_BYTE, MODE_OFF,
                                      MODE_LOG, MODE_WORD, MODE_LOG};

  logic             clk_i     = 1'b0;
  logic             rst_ni    = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  op_e              op        = OP_ACCUM;
  logic [PIX_W-1:0] pixel     = '0;
  logic [IDX_W-1:0] bin_sel   = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [CNT_W-1:0] bin_count;
  logic [IDX_W-1:0] bin_echo;
  logic             psel      = 1'b0;
  logic             penable   = 1'b0;
  logic             pwrite    = 1'b0;
  logic [2:0]       paddr     = '0;
  logic [31:0]      pwdata    = '0;
  logic [31:0]      prdata;
  logic             pready;
  int               err_count;
  int               due_count;
  bit               no_idle   = 1'b0;
  bit               hold_req  = 1'b0;
  logic [IDX_W-1:0] hot_bins [8];

  intensity_histogram_log_bins u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .op_i          (op),
    .pixel_value_i (pixel),
    .bin_select_i  (bin_sel),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .bin_count_o   (bin_count),
    .bin_echo_o    (bin_echo),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  ihl_hist_checker #(.MODE_ADDR(MODE_ADDR)) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .op_i          (op),
    .pixel_value_i (pixel),
    .bin_select_i  (bin_sel),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .bin_count_i   (bin_count),
    .bin_echo_i    (bin_echo),
    .psel_i        (psel),
    .penable_i     (penable),
    .pwrite_i      (pwrite),
    .paddr_i       (paddr),
    .pwdata_i      (pwdata),
    .prdata_i      (prdata),
    .pready_i      (pready),
    .errors_o      (err_count),
    .pending_o     (due_count)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // result side: random stall per item, one long hold on request
  initial begin
    int n;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      n = no_idle ? 0 : $urandom_range(0, 5);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall <= 1'b0;
      do @(posedge clk_i); while (!out_valid || out_stall);
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("FAIL intensity_histogram_log_bins");
    $finish;
  end

  task automatic send_item(op_e o, logic [PIX_W-1:0] p, logic [IDX_W-1:0] s);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    op       <= o;
    pixel    <= p;
    bin_sel  <= s;
    do @(posedge clk_i); while (in_stall);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (due_count != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // write pixel_mode, then read it back
  task automatic set_mode(mode_e m);
    settle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= MODE_ADDR;
    pwdata  <= 32'(m);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // pixel one below, at or one above the k-th log edge
  function automatic logic [PIX_W-1:0] near_edge(int k);
    real    r;
    longint t;
    r = $exp($ln(4294967295.0) * real'(k) / real'(LOG_STEPS));
    t = longint'($ceil(r)) + longint'($urandom_range(0, 2)) - 1;
    if (t < 1) t = 1;
    if (t > longint'(FULL_SCALE)) t = longint'(FULL_SCALE);
    return t[PIX_W-1:0];
  endfunction

  task automatic random_item(mode_e m);
    int               pick;
    op_e              o;
    logic [PIX_W-1:0] p;
    logic [IDX_W-1:0] s;
    logic [IDX_W-1:0] hot;
    pick = $urandom_range(0, 99);
    if (pick < 55) o = OP_ACCUM;
    else if (pick < 75) o = OP_READ;
    else if (pick < 95) o = OP_READ_CLR;
    else o = OP_NONE;
    hot = hot_bins[$urandom_range(0, 7)];
    p   = $urandom;
    if (m == MODE_LOG) begin
      pick = $urandom_range(0, 9);
      if (pick < 3) p = near_edge(hot[7:0] == 8'd0 ? 1 : int'(hot[7:0]));
      else if (pick < 5) p = near_edge($urandom_range(1, LOG_STEPS));
      else if (pick < 8) p = p >> $urandom_range(0, 31);
    end else if ($urandom_range(0, 7) != 0) begin
      p[15:0] = hot;
    end
    s = IDX_W'($urandom);
    if ($urandom_range(0, 9) < 7) begin
      case (m)
        MODE_LOG:  s = IDX_W'(hot[7:0] - 8'(($urandom_range(0, 1))));
        MODE_BYTE: s = IDX_W'(hot[7:0]);
        default:   s = hot;
      endcase
    end
    send_item(o, p, s);
  endtask

  initial begin
    for (int i = 0; i < 8; i++) hot_bins[i] = IDX_W'($urandom);
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    set_mode(MODE_BYTE);
    send_item(OP_ACCUM, 32'h0000_0000, 16'h0000);
    send_item(OP_ACCUM, 32'hFFFF_FFFF, 16'hFFFF);
    send_item(OP_ACCUM, 32'h0000_0100, 16'h0000);
    send_item(OP_NONE, PIX_W'($urandom), IDX_W'($urandom));
    send_item(OP_READ, 32'h0, 16'h0000);
    send_item(OP_READ_CLR, 32'h0, 16'h00FF);
    send_item(OP_READ, 32'h0, 16'h00FF);
    send_item(OP_READ, 32'h0, 16'hFFFF);

    set_mode(MODE_WORD);
    send_item(OP_ACCUM, 32'hFFFF_FFFF, 16'h0);
    send_item(OP_ACCUM, 32'h0001_0000, 16'h0);
    send_item(OP_READ, 32'h0, 16'h0000);
    send_item(OP_READ_CLR, 32'h0, 16'hFFFF);

    set_mode(MODE_LOG);
    send_item(OP_ACCUM, 32'h0000_0000, 16'h0);
    send_item(OP_ACCUM, 32'h0000_0001, 16'h0);
    send_item(OP_ACCUM, 32'h0000_0002, 16'h0);
    send_item(OP_ACCUM, 32'hFFFF_FFFF, 16'h0);
    send_item(OP_ACCUM, 32'h8000_0000, 16'h0);
    send_item(OP_READ, 32'h0, 16'h0000);
    send_item(OP_READ, 32'h0, 16'h0001);
    send_item(OP_READ_CLR, 32'h0, 16'h00FF);
    send_item(OP_READ, 32'h0, 16'd300);

    set_mode(MODE_OFF);
    send_item(OP_ACCUM, 32'h0000_0005, 16'h0);
    send_item(OP_READ, 32'h0, 16'h0005);
    send_item(OP_READ_CLR, 32'h0, 16'h0000);

    for (int ph = 0; ph < 7; ph++) begin
      set_mode(PLAN[ph]);
      if (ph == 1) begin
        hold_req = 1'b1;
        no_idle  = 1'b1;
        repeat (40) send_item(OP_READ, PIX_W'($urandom), IDX_W'($urandom_range(0, 255)));
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 20 == 0) no_idle = ($urandom_range(0, 3) == 0);
        random_item(PLAN[ph]);
      end
    end
    no_idle = 1'b0;
    settle();

    if (err_count == 0 && due_count == 0) begin
      $display("PASS intensity_histogram_log_bins");
    end else begin
      $display("FAIL intensity_histogram_log_bins");
    end
    $finish;
  end

endmodule
